// ===== rtl/plec_pkg.sv =====
package plec_pkg;

	localparam int REF_W = 16;
	localparam int ERR_W = 17;
	localparam int GAIN_W = 32;
	localparam int SUM_W = 32;
	localparam int PER_W = 16;
	localparam int DRV_W = 48;
	localparam int TOT_W = 62;
	localparam int TERM_W = 61;
	localparam int DM_W = 27;
	localparam int ACC_W = 80;
	localparam int MPL_W = 32;
	localparam int CNT_W = 7;
	localparam int IDX_W = 3;
	localparam int CFG_W = 32;

	localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd2;
	localparam logic [IDX_W-1:0] REG_SETPOINT = 3'd3;
	localparam logic [IDX_W-1:0] REG_PERIOD = 3'd4;

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	localparam logic [CNT_W-1:0] N_P = 7'd17;
	localparam logic [CNT_W-1:0] N_I1 = 7'd32;
	localparam logic [CNT_W-1:0] N_I2 = 7'd16;
	localparam logic [CNT_W-1:0] N_ID = 7'd78;
	localparam logic [CNT_W-1:0] N_D1 = 7'd27;
	localparam logic [CNT_W-1:0] N_DD = 7'd59;

	localparam logic [MPL_W-1:0] TIME_SCALE = 32'd1000;
	localparam logic [TERM_W-1:0] TERM_LIM = {1'b1, 60'd0};
	localparam logic [DRV_W-1:0] DRIVE_MAX = {1'b0, {(DRV_W-1){1'b1}}};
	localparam logic [DRV_W-1:0] DRIVE_MIN = {1'b1, {(DRV_W-1){1'b0}}};

	typedef struct packed {
		logic start;
		logic op;
		logic [ACC_W-1:0] a;
		logic [MPL_W-1:0] b;
		logic [CNT_W-1:0] n;
	} plec_cmd_t;

	typedef struct packed {
		logic done;
		logic [ACC_W-1:0] res;
	} plec_rsp_t;

	function automatic logic [GAIN_W-1:0] mag32(input logic [GAIN_W-1:0] v);
		return v[GAIN_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic signed [TOT_W-1:0] signed_term(input logic [TERM_W-1:0] m,
			input logic neg);
		logic [TOT_W-1:0] x;
		x = {1'b0, m};
		return neg ? signed'(~x + 1'b1) : signed'(x);
	endfunction

endpackage

// ===== rtl/plec_if.sv =====
interface plec_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] reference;
	logic restart;

	modport source (output valid, output reference, output restart, input ready);
	modport sink (input valid, input reference, input restart, output ready);
endinterface

interface plec_out_if;
	logic valid;
	logic ready;
	logic signed [47:0] drive;
	logic clipped;

	modport source (output valid, output drive, output clipped, input ready);
	modport sink (input valid, input drive, input clipped, output ready);
endinterface

// ===== rtl/plec_serial.sv =====
module plec_serial
	import plec_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input plec_cmd_t cmd,
	output plec_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	logic op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] mcand_q;
	logic [MPL_W-1:0] mplier_q;
	logic [PER_W-1:0] rem_q;

	logic [PER_W:0] trial;
	logic [PER_W:0] diff;
	logic fits;

	assign trial = {rem_q, acc_q[ACC_W-1]};
	assign fits = trial >= {1'b0, mplier_q[PER_W-1:0]};
	assign diff = trial - {1'b0, mplier_q[PER_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= cmd.n;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= cmd.op;
			mplier_q <= cmd.b;
			mcand_q <= cmd.a;
			rem_q <= '0;
			acc_q <= (cmd.op == OP_MUL) ? '0 : cmd.a;
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					if (mplier_q[0])
						acc_q <= acc_q + mcand_q;
					mcand_q <= {mcand_q[ACC_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
				end
				OP_DIV: begin
					acc_q <= {acc_q[ACC_W-2:0], fits};
					rem_q <= fits ? diff[PER_W-1:0] : trial[PER_W-1:0];
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = acc_q;

endmodule

// ===== rtl/pid_line_error_controller_unit.sv =====
// PID controller for a line-position sensor.
// sample channel: one word per sampling period, a signed 16-bit reference and
// a restart flag that clears the error sum and the previous error first.
// control channel: one word per sample, the signed Q32.16 drive, saturated to
// 48 bits, and a clipped flag set when saturation happened.
// Configuration: cfg_we/cfg_index/cfg_data write gain_p, gain_i, gain_d
// (signed Q16.16), setpoint and period_ms; write only while no sample is in
// flight. A period of zero acts as one.
// The drive word is computed in the states S_P_GO through S_DD_WT and loaded
// into the output register from S_OUT; the next sample is taken only back in
// S_IDLE. Six multiply and divide passes run in turn on one shared unit that
// retires one bit per cycle (17, 32, 16, 78, 27 and 59 bit steps in the passes).
// Reset clears gains and setpoint to zero, period to one, and the error history.
// A stalled receiver holds the drive word in the output register; the next
// sample is still taken and computed, and waits until that register frees.
module pid_line_error_controller_unit
	import plec_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	plec_in_if.sink sample,
	plec_out_if.source control
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_P_GO = 4'd1;
	localparam logic [3:0] S_P_WT = 4'd2;
	localparam logic [3:0] S_I1_GO = 4'd3;
	localparam logic [3:0] S_I1_WT = 4'd4;
	localparam logic [3:0] S_I2_GO = 4'd5;
	localparam logic [3:0] S_I2_WT = 4'd6;
	localparam logic [3:0] S_ID_GO = 4'd7;
	localparam logic [3:0] S_ID_WT = 4'd8;
	localparam logic [3:0] S_D1_GO = 4'd9;
	localparam logic [3:0] S_D1_WT = 4'd10;
	localparam logic [3:0] S_DD_GO = 4'd11;
	localparam logic [3:0] S_DD_WT = 4'd12;
	localparam logic [3:0] S_OUT = 4'd13;

	logic [3:0] state_q;
	logic [GAIN_W-1:0] gain_p_q;
	logic [GAIN_W-1:0] gain_i_q;
	logic [GAIN_W-1:0] gain_d_q;
	logic [REF_W-1:0] setpoint_q;
	logic [PER_W-1:0] period_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [ERR_W-1:0] last_q;
	logic [ERR_W-1:0] e_mag_q;
	logic e_neg_q;
	logic [DM_W-1:0] dm_q;
	logic d_neg_q;
	logic signed [TOT_W-1:0] total_q;
	logic out_valid_q;
	logic [DRV_W-1:0] drive_q;
	logic clipped_q;

	plec_cmd_t cmd;
	plec_rsp_t rsp;

	logic accept;
	logic out_free;
	logic [PER_W-1:0] t_eff;
	logic signed [ERR_W-1:0] e;
	logic signed [SUM_W-1:0] sum_base;
	logic signed [ERR_W-1:0] last_base;
	logic signed [SUM_W:0] sum_wide;
	logic signed [SUM_W-1:0] sum_sat;
	logic signed [ERR_W:0] de;
	logic [ERR_W-1:0] de_mag;
	logic [DM_W-1:0] dm;
	logic [ERR_W-1:0] e_mag;
	logic [TERM_W-1:0] p_mag;
	logic [TERM_W-1:0] i_mag;
	logic [TERM_W-1:0] d_mag;
	logic i_over;
	logic sat;
	logic [DRV_W-1:0] drive_next;

	plec_serial u_serial (
		.clk (clk),
		.arst_n (arst_n),
		.cmd (cmd),
		.rsp (rsp)
	);

	assign accept = sample.valid && sample.ready;
	assign sample.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || control.ready;
	assign t_eff = (period_q == '0) ? 16'd1 : period_q;

	assign e = signed'({sample.reference[REF_W-1], sample.reference})
		- signed'({setpoint_q[REF_W-1], setpoint_q});
	assign e_mag = e[ERR_W-1] ? (~e + 1'b1) : e;
	assign sum_base = sample.restart ? '0 : sum_q;
	assign last_base = sample.restart ? '0 : last_q;
	assign sum_wide = {sum_base[SUM_W-1], sum_base} + {{(SUM_W-ERR_W+1){e[ERR_W-1]}}, e};
	assign de = {e[ERR_W-1], e} - {last_base[ERR_W-1], last_base};
	assign de_mag = de[ERR_W] ? ERR_W'(~de + 1'b1) : de[ERR_W-1:0];
	assign dm = {de_mag, 10'd0} - {6'd0, de_mag, 4'd0} - {7'd0, de_mag, 3'd0};

	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_sat = sum_wide[SUM_W-1:0];
	end

	assign p_mag = {13'd0, rsp.res[DRV_W-1:0]};
	assign i_over = (rsp.res[ACC_W-1:TERM_W] != '0)
		|| (rsp.res[TERM_W-1] && (rsp.res[TERM_W-2:0] != '0));
	assign i_mag = i_over ? TERM_LIM : rsp.res[TERM_W-1:0];
	assign d_mag = {2'd0, rsp.res[N_DD-1:0]};

	assign sat = !((&total_q[TOT_W-1:DRV_W-1]) || !(|total_q[TOT_W-1:DRV_W-1]));
	assign drive_next = sat ? (total_q[TOT_W-1] ? DRIVE_MIN : DRIVE_MAX)
		: total_q[DRV_W-1:0];

	always_comb begin
		cmd.start = 1'b0;
		cmd.op = OP_MUL;
		cmd.a = '0;
		cmd.b = '0;
		cmd.n = '0;
		case (state_q)
			S_P_GO: begin
				cmd.start = 1'b1;
				cmd.a = {48'd0, mag32(gain_p_q)};
				cmd.b = {15'd0, e_mag_q};
				cmd.n = N_P;
			end
			S_I1_GO: begin
				cmd.start = 1'b1;
				cmd.a = {48'd0, mag32(gain_i_q)};
				cmd.b = mag32(sum_q);
				cmd.n = N_I1;
			end
			S_I2_GO: begin
				cmd.start = 1'b1;
				cmd.a = rsp.res;
				cmd.b = {16'd0, t_eff};
				cmd.n = N_I2;
			end
			S_ID_GO: begin
				cmd.start = 1'b1;
				cmd.op = OP_DIV;
				cmd.a = {rsp.res[N_ID-1:0], 2'd0};
				cmd.b = TIME_SCALE;
				cmd.n = N_ID;
			end
			S_D1_GO: begin
				cmd.start = 1'b1;
				cmd.a = {48'd0, mag32(gain_d_q)};
				cmd.b = {5'd0, dm_q};
				cmd.n = N_D1;
			end
			S_DD_GO: begin
				cmd.start = 1'b1;
				cmd.op = OP_DIV;
				cmd.a = {rsp.res[N_DD-1:0], 21'd0};
				cmd.b = {16'd0, t_eff};
				cmd.n = N_DD;
			end
			default: begin
				cmd.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			setpoint_q <= '0;
			period_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P: gain_p_q <= cfg_data;
				REG_GAIN_I: gain_i_q <= cfg_data;
				REG_GAIN_D: gain_d_q <= cfg_data;
				REG_SETPOINT: setpoint_q <= cfg_data[REF_W-1:0];
				REG_PERIOD: period_q <= cfg_data[PER_W-1:0];
				default: period_q <= period_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q <= '0;
			last_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sum_q <= sum_sat;
						last_q <= e;
						state_q <= S_P_GO;
					end
				end
				S_P_GO: state_q <= S_P_WT;
				S_P_WT: if (rsp.done) state_q <= S_I1_GO;
				S_I1_GO: state_q <= S_I1_WT;
				S_I1_WT: if (rsp.done) state_q <= S_I2_GO;
				S_I2_GO: state_q <= S_I2_WT;
				S_I2_WT: if (rsp.done) state_q <= S_ID_GO;
				S_ID_GO: state_q <= S_ID_WT;
				S_ID_WT: if (rsp.done) state_q <= S_D1_GO;
				S_D1_GO: state_q <= S_D1_WT;
				S_D1_WT: if (rsp.done) state_q <= S_DD_GO;
				S_DD_GO: state_q <= S_DD_WT;
				S_DD_WT: if (rsp.done) state_q <= S_OUT;
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_mag_q <= e_mag;
			e_neg_q <= e[ERR_W-1];
			dm_q <= dm;
			d_neg_q <= de[ERR_W];
		end
		if (rsp.done) begin
			case (state_q)
				S_P_WT: total_q <= signed_term(p_mag, gain_p_q[GAIN_W-1] ^ e_neg_q);
				S_ID_WT: total_q <= total_q
					+ signed_term(i_mag, gain_i_q[GAIN_W-1] ^ sum_q[SUM_W-1]);
				S_DD_WT: total_q <= total_q
					+ signed_term(d_mag, gain_d_q[GAIN_W-1] ^ d_neg_q);
				default: total_q <= total_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (control.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			drive_q <= drive_next;
			clipped_q <= sat;
		end
	end

	assign control.valid = out_valid_q;
	assign control.drive = drive_q;
	assign control.clipped = clipped_q;

endmodule

// ===== dv/testbench.sv =====
module testbench
	import plec_pkg::*;
();

	typedef longint unsigned u64_t;

	typedef struct {
		logic [47:0] drive;
		logic clipped;
	} drive_word_t;

	localparam int RANDOM_WORDS = 1830;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 250;
	localparam longint SUM_HI = (longint'(1) << 31) - 1;
	localparam longint SUM_LO = -(longint'(1) << 31);
	localparam longint DRV_HI = (longint'(1) << 47) - 1;
	localparam longint DRV_LO = -(longint'(1) << 47);
	localparam u64_t INTEG_CLAMP = u64_t'(1) << 60;
	localparam u64_t MS_PER_S = u64_t'(1000);

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	plec_in_if sample_ch();
	plec_out_if control_ch();

	pid_line_error_controller_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample_ch),
		.control(control_ch)
	);

	longint kp = 0;
	longint ki = 0;
	longint kd = 0;
	longint target = 0;
	u64_t period = 1;
	longint err_sum = 0;
	longint prev_err = 0;

	drive_word_t pending_drive[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit rx_steady = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic u64_t magnitude(input longint v);
		u64_t r;
		r = (v < 0) ? -v : v;
		return r;
	endfunction

	function automatic drive_word_t compute_drive(input logic signed [15:0] position,
			input logic rst);
		drive_word_t w;
		longint e, de, s, p_t, i_t, d_t, total;
		u64_t t, a, q, r, m;
		if (rst) begin
			err_sum = 0;
			prev_err = 0;
		end
		t = (period == 0) ? 1 : period;
		e = longint'(position) - target;
		s = err_sum + e;
		if (s > SUM_HI)
			s = SUM_HI;
		else if (s < SUM_LO)
			s = SUM_LO;
		err_sum = s;
		p_t = kp * e;
		a = magnitude(ki) * magnitude(err_sum);
		q = a / MS_PER_S;
		r = a % MS_PER_S;
		if (q > INTEG_CLAMP / t) begin
			m = INTEG_CLAMP;
		end else begin
			m = q * t + (r * t) / MS_PER_S;
			if (m > INTEG_CLAMP)
				m = INTEG_CLAMP;
		end
		i_t = ((ki < 0) != (err_sum < 0)) ? -longint'(m) : longint'(m);
		de = e - prev_err;
		m = (magnitude(kd) * magnitude(de) * MS_PER_S) / t;
		d_t = ((kd < 0) != (de < 0)) ? -longint'(m) : longint'(m);
		total = p_t + i_t + d_t;
		w.clipped = 1'b0;
		if (total > DRV_HI) begin
			total = DRV_HI;
			w.clipped = 1'b1;
		end
		if (total < DRV_LO) begin
			total = DRV_LO;
			w.clipped = 1'b1;
		end
		prev_err = e;
		w.drive = total[47:0];
		return w;
	endfunction

	always @(posedge clk) begin
		drive_word_t want;
		if (arst_n && control_ch.valid && control_ch.ready) begin
			if (pending_drive.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected drive word %h clipped %b", control_ch.drive,
						control_ch.clipped);
			end else begin
				want = pending_drive.pop_front();
				if (want.drive !== control_ch.drive || want.clipped !== control_ch.clipped) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("drive mismatch: expected %h clipped %b, got %h clipped %b",
							want.drive, want.clipped, control_ch.drive, control_ch.clipped);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (control_ch.valid && control_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		int roll;
		control_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			roll = $urandom_range(0, 99);
			if (rx_steady || roll < 70) begin
				control_ch.ready <= 1'b1;
			end else begin
				control_ch.ready <= 1'b0;
				n = (roll < 95) ? $urandom_range(1, 4) : $urandom_range(20, 300);
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic send_sample(input logic signed [15:0] position, input logic rst);
		sample_ch.valid <= 1'b1;
		sample_ch.reference <= position;
		sample_ch.restart <= rst;
		do @(posedge clk); while (!sample_ch.ready);
		pending_drive.push_back(compute_drive(position, rst));
		@(negedge clk);
	endtask

	task automatic pace_source(input bit steady);
		int roll;
		int gap;
		if (steady)
			return;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			gap = 0;
		else if (roll < 95)
			gap = $urandom_range(1, 4);
		else
			gap = $urandom_range(20, 300);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_words();
		sample_ch.valid <= 1'b0;
		while (pending_drive.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [31:0] gp, input logic [31:0] gi,
			input logic [31:0] gd, input logic [15:0] sp, input logic [15:0] per);
		logic [IDX_W-1:0] idx_list[5];
		logic [CFG_W-1:0] val_list[5];
		logic [31:0] junk;
		drain_words();
		junk = $urandom;
		idx_list = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_SETPOINT, REG_PERIOD};
		val_list = '{gp, gi, gd, {junk[31:16], sp}, {junk[15:0], per}};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data <= val_list[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		kp = longint'(signed'(gp));
		ki = longint'(signed'(gi));
		kd = longint'(signed'(gd));
		target = longint'(signed'(sp));
		period = u64_t'(per);
	endtask

	function automatic logic [31:0] pick_gain();
		logic [31:0] g;
		case ($urandom_range(0, 7))
			0: g = 32'h7FFF_FFFF;
			1: g = 32'h8000_0000;
			2: g = 32'h0;
			3, 4, 5: g = $urandom_range(0, 32'h7FFFF) - 32'h40000;
			default: g = $urandom;
		endcase
		return g;
	endfunction

	function automatic logic [15:0] pick_period();
		logic [15:0] t;
		case ($urandom_range(0, 5))
			0: t = 16'd0;
			1: t = 16'd1;
			2: t = 16'hFFFF;
			3, 4: t = 16'($urandom_range(1, 20));
			default: t = 16'($urandom);
		endcase
		return t;
	endfunction

	function automatic logic signed [15:0] pick_position(input logic signed [15:0] sp);
		logic signed [15:0] x;
		case ($urandom_range(0, 9))
			0: x = 16'sh7FFF;
			1: x = 16'sh8000;
			2, 3, 4: x = 16'(sp + $urandom_range(0, 128) - 64);
			default: x = 16'($urandom);
		endcase
		return x;
	endfunction

	task automatic test_reset_state();
		send_sample(16'sh7FFF, 1'b0);
		pace_source(0);
		send_sample(16'sh8000, 1'b0);
	endtask

	task automatic test_proportional_extremes();
		set_config(32'h0001_0000, 32'h0, 32'h0, 16'h0, 16'd1);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		pace_source(0);
		send_sample(16'sh0000, 1'b0);
		send_sample(-16'sd1, 1'b0);
	endtask

	task automatic test_integral_derivative();
		set_config(32'h0, 32'h0001_8000, 32'hFFFF_0000, 16'd1234, 16'd3);
		send_sample(16'sd2000, 1'b1);
		send_sample(16'sd5000, 1'b0);
		pace_source(0);
		send_sample(-16'sd3000, 1'b0);
		send_sample(16'sd1234, 1'b1);
		send_sample(16'sd100, 1'b0);
	endtask

	task automatic test_period_edges();
		set_config(32'h0000_4000, 32'h0003_0000, 32'h0002_0000, 16'hFF00, 16'd0);
		send_sample(16'sd700, 1'b1);
		send_sample(-16'sd900, 1'b0);
		set_config(32'h0000_4000, 32'h7FFF_FFFF, 32'h0002_0000, 16'hFF00, 16'hFFFF);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
	endtask

	task automatic test_drive_clip();
		set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 16'd1);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		set_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'd1);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
	endtask

	task automatic test_random_phases();
		int sent;
		int len;
		bit windup;
		bit steady;
		logic [15:0] sp;
		logic signed [15:0] position;
		logic rst;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			windup = ($urandom_range(0, 9) == 0);
			if (windup) begin
				sp = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
				set_config(pick_gain(), $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
					pick_gain(), sp, 16'hFFFF);
				len = 160;
			end else begin
				sp = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF)
					: 16'($urandom);
				set_config(pick_gain(), pick_gain(), pick_gain(), sp, pick_period());
				len = $urandom_range(20, 60);
			end
			steady = ($urandom_range(0, 4) == 0);
			rx_steady = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < len; k++) begin
				if (windup) begin
					position = 16'(sp[15] ? 16'sh7FFF - $urandom_range(0, 255)
						: 16'sh8000 + $urandom_range(0, 255));
					rst = (k == 0);
				end else begin
					position = pick_position(sp);
					rst = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 8);
				end
				send_sample(position, rst);
				sent++;
				pace_source(steady);
			end
		end
		rx_steady = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.reference = '0;
		sample_ch.restart = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_state();
		test_proportional_extremes();
		test_integral_derivative();
		test_period_edges();
		test_drive_clip();
		test_random_phases();
		drain_words();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
